[sv/esc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esc_pkg
// shared types and constants of the event statistics collector
// ----------------------------------------------------------------------------
package esc_pkg;

  localparam int DEFAULT_NUM_CATEGORIES = 16;
  localparam int STAT_W                 = 64;
  localparam int CAT_W                  = 4;
  localparam int MODE_W                 = 2;
  localparam int CNT_EXT_W              = 9;

  typedef enum logic [MODE_W-1:0] {
    MODE_RECORD       = 2'd0,
    MODE_DUMP         = 2'd1,
    MODE_CLEAR_TOTALS = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REC_WR,
    ST_DUMP_RD,
    ST_DUMP_LD
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic rec_rd;
    logic rec_wr;
    logic clr_tot;
    logic dump_start;
    logic dump_rd;
    logic out_load;
    logic dump_next;
    logic clr_win;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic cat_ok;
    logic dump_last;
    logic out_busy;
  } sts_t;

endpackage

[sv/esc_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esc_ctrl
// sequencer for record, dump and clear operations
// ----------------------------------------------------------------------------
module esc_ctrl
  import esc_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_tvalid,
  input  mode_t in_mode,
  output logic  in_tready,
  input  sts_t  sts,
  output cmd_t  cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          unique case (in_mode)
            MODE_RECORD: begin
              if (sts.cat_ok) begin
                cmd.rec_rd = 1'b1;
                state_nxt  = ST_REC_WR;
              end
            end
            MODE_DUMP: begin
              cmd.dump_start = 1'b1;
              state_nxt      = ST_DUMP_RD;
            end
            MODE_CLEAR_TOTALS: begin
              cmd.clr_tot = 1'b1;
            end
            default: ;
          endcase
        end
      end
      ST_REC_WR: begin
        cmd.rec_wr = 1'b1;
        state_nxt  = ST_IDLE;
      end
      ST_DUMP_RD: begin
        cmd.dump_rd = 1'b1;
        state_nxt   = ST_DUMP_LD;
      end
      ST_DUMP_LD: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          if (sts.dump_last) begin
            cmd.clr_win = 1'b1;
            state_nxt   = ST_IDLE;
          end else begin
            cmd.dump_next = 1'b1;
            state_nxt     = ST_DUMP_RD;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

[sv/esc_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esc_dp
// statistics memory, update arithmetic and result register
// ----------------------------------------------------------------------------
module esc_dp
  import esc_pkg::*;
#(
  parameter int NUM_CATEGORIES = DEFAULT_NUM_CATEGORIES
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [CAT_W-1:0]  in_category,
  input  logic [STAT_W-1:0] in_sample_value,
  input  cmd_t              cmd,
  output sts_t              sts,
  input  logic              out_tready,
  output logic              out_tvalid,
  output logic [CAT_W-1:0]  out_entry_index,
  output logic [STAT_W-1:0] out_all_count,
  output logic [STAT_W-1:0] out_all_sum,
  output logic [STAT_W-1:0] out_window_count_out,
  output logic [STAT_W-1:0] out_window_sum_out,
  output logic [STAT_W-1:0] out_window_max_out,
  output logic [STAT_W-1:0] out_window_min_out,
  output logic              out_last_entry
);

  localparam int IDX_W = (NUM_CATEGORIES > 1) ? $clog2(NUM_CATEGORIES) : 1;

  typedef struct packed {
    logic [STAT_W-1:0] tsum;
    logic [STAT_W-1:0] tcount;
    logic [STAT_W-1:0] wsum;
    logic [STAT_W-1:0] wcount;
    logic [STAT_W-1:0] wmax;
    logic [STAT_W-1:0] wmin;
  } row_t;

  row_t                    mem [NUM_CATEGORIES];
  logic [NUM_CATEGORIES-1:0] tvld_r;
  logic [NUM_CATEGORIES-1:0] wvld_r;

  row_t              rd_row_r;
  logic              rd_tvld_r;
  logic              rd_wvld_r;
  logic [IDX_W-1:0]  cat_r;
  logic [STAT_W-1:0] val_r;
  logic [IDX_W-1:0]  k_r;
  logic              out_valid_r;

  logic [IDX_W-1:0]     cat_addr;
  logic [IDX_W-1:0]     rd_addr;
  logic                 rd_en;
  logic [CNT_EXT_W-1:0] k_ext;
  row_t                 eff;
  row_t                 upd;

  assign cat_addr = IDX_W'(in_category);
  assign rd_addr  = cmd.rec_rd ? cat_addr : k_r;
  assign rd_en    = cmd.rec_rd | cmd.dump_rd;
  assign k_ext    = CNT_EXT_W'(k_r);

  assign sts.cat_ok    = CNT_EXT_W'(in_category) < CNT_EXT_W'(NUM_CATEGORIES);
  assign sts.dump_last = k_r == IDX_W'(NUM_CATEGORIES - 1);
  assign sts.out_busy  = out_valid_r & ~out_tready;

  // entries without a valid bit read as their reset value
  always_comb begin
    eff.tsum   = rd_tvld_r ? rd_row_r.tsum   : '0;
    eff.tcount = rd_tvld_r ? rd_row_r.tcount : '0;
    eff.wsum   = rd_wvld_r ? rd_row_r.wsum   : '0;
    eff.wcount = rd_wvld_r ? rd_row_r.wcount : '0;
    eff.wmax   = rd_wvld_r ? rd_row_r.wmax   : '0;
    eff.wmin   = rd_wvld_r ? rd_row_r.wmin   : '1;
  end

  always_comb begin
    upd.tsum   = eff.tsum + val_r;
    upd.tcount = eff.tcount + STAT_W'(1);
    upd.wsum   = eff.wsum + val_r;
    upd.wcount = eff.wcount + STAT_W'(1);
    upd.wmax   = (val_r > eff.wmax) ? val_r : eff.wmax;
    upd.wmin   = (val_r < eff.wmin) ? val_r : eff.wmin;
  end

  always_ff @(posedge clk) begin
    if (cmd.rec_wr) begin
      mem[cat_r] <= upd;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_row_r  <= mem[rd_addr];
      rd_tvld_r <= tvld_r[rd_addr];
      rd_wvld_r <= wvld_r[rd_addr];
    end
    if (cmd.rec_rd) begin
      cat_r <= cat_addr;
      val_r <= in_sample_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tvld_r <= '0;
      wvld_r <= '0;
      k_r    <= '0;
    end else begin
      if (cmd.clr_tot) begin
        tvld_r <= '0;
      end else if (cmd.rec_wr) begin
        tvld_r[cat_r] <= 1'b1;
      end
      if (cmd.clr_win) begin
        wvld_r <= '0;
      end else if (cmd.rec_wr) begin
        wvld_r[cat_r] <= 1'b1;
      end
      if (cmd.dump_start) begin
        k_r <= '0;
      end else if (cmd.dump_next) begin
        k_r <= k_r + IDX_W'(1);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_entry_index      <= k_ext[CAT_W-1:0];
      out_all_count        <= eff.tcount;
      out_all_sum          <= eff.tsum;
      out_window_count_out <= eff.wcount;
      out_window_sum_out   <= eff.wsum;
      out_window_max_out   <= eff.wmax;
      out_window_min_out   <= (eff.wcount != '0) ? eff.wmin : '0;
      out_last_entry       <= sts.dump_last;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

[sv/event_statistics_collector.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// event_statistics_collector
// per-category totals and window statistics with dump and clear
//
//   channel  direction  tdata (low bit up)                        tuser / tlast
//   in_      slave      category, sample_value                    tuser: mode
//   out_     master     entry_index, all_count, all_sum,          tlast: last_entry
//                       window_count_out, window_sum_out,
//                       window_max_out, window_min_out
//
// a record is a memory read, then add/compare and write back
// a dump accepts the item, then reads each category through the single memory read
//   port and loads the result register, waiting while a result waits on out_tready
// clear totals and ignored items are handled in the idle state
// reset is synchronous; stores are cleared by per-row valid bits, no sweep
// ----------------------------------------------------------------------------
module event_statistics_collector
  import esc_pkg::*;
#(
  parameter int NUM_CATEGORIES = DEFAULT_NUM_CATEGORIES
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [71:0]  in_tdata,   // category, sample_value, zero pad
  input  logic [1:0]   in_tuser,   // mode
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [391:0] out_tdata,  // entry_index, all_count, all_sum, window_count_out,
                                   // window_sum_out, window_max_out, window_min_out, pad
  output logic         out_tlast
);

  cmd_t cmd;
  sts_t sts;

  logic [CAT_W-1:0]  in_category;
  logic [STAT_W-1:0] in_sample_value;
  mode_t             in_mode;

  logic [CAT_W-1:0]  out_entry_index;
  logic [STAT_W-1:0] out_all_count;
  logic [STAT_W-1:0] out_all_sum;
  logic [STAT_W-1:0] out_window_count_out;
  logic [STAT_W-1:0] out_window_sum_out;
  logic [STAT_W-1:0] out_window_max_out;
  logic [STAT_W-1:0] out_window_min_out;

  assign in_mode         = mode_t'(in_tuser);
  assign in_category     = in_tdata[3:0];
  assign in_sample_value = in_tdata[67:4];

  assign out_tdata = {4'b0, out_window_min_out, out_window_max_out, out_window_sum_out,
                      out_window_count_out, out_all_sum, out_all_count, out_entry_index};

  esc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_mode   (in_mode),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  esc_dp #(
    .NUM_CATEGORIES (NUM_CATEGORIES)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_category          (in_category),
    .in_sample_value      (in_sample_value),
    .cmd                  (cmd),
    .sts                  (sts),
    .out_tready           (out_tready),
    .out_tvalid           (out_tvalid),
    .out_entry_index      (out_entry_index),
    .out_all_count        (out_all_count),
    .out_all_sum          (out_all_sum),
    .out_window_count_out (out_window_count_out),
    .out_window_sum_out   (out_window_sum_out),
    .out_window_max_out   (out_window_max_out),
    .out_window_min_out   (out_window_min_out),
    .out_last_entry       (out_tlast)
  );

  // a waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !(out_tvalid && !out_tready))
    else $error("result register loaded while a transfer is pending");

  // windows clear only with the final result of a dump
  a_clr_win_last: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clr_win |-> (cmd.out_load && sts.dump_last))
    else $error("window cleared outside the last dump result");

  // every record read is followed by its write back
  a_rec_wb: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rec_rd |=> (cmd.rec_wr && !in_tready))
    else $error("record read without write back");

  // a record read only starts from an accepted transfer
  a_rec_acc: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rec_rd |-> (in_tvalid && in_tready && sts.cat_ok))
    else $error("record read without an accepted item");

endmodule

[tb/event_statistics_collector_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// event_statistics_collector_tb
// self-checking bench for the event statistics collector: a queue-fed driver
// sends record, dump, clear-totals and unused-mode transfers with random gaps,
// a clocked monitor keeps its own copy of the per-category totals and windows,
// and every dump row is checked field by field against that copy
// ----------------------------------------------------------------------------
module event_statistics_collector_tb;
  import esc_pkg::*;

  localparam int NCAT = DEFAULT_NUM_CATEGORIES;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 360;
  localparam int BURST_ITEMS = 32;
  localparam int MAX_GAP = 18;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 100;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int REPORT_LIMIT = 10;

  typedef struct {
    logic [MODE_W-1:0] mode;
    logic [CAT_W-1:0]  category;
    logic [STAT_W-1:0] sample;
    int unsigned       gap;
    bit                drain;
  } event_item_t;

  typedef struct {
    logic [CAT_W-1:0]  index;
    logic [STAT_W-1:0] all_count;
    logic [STAT_W-1:0] all_sum;
    logic [STAT_W-1:0] win_count;
    logic [STAT_W-1:0] win_sum;
    logic [STAT_W-1:0] win_max;
    logic [STAT_W-1:0] win_min;
    logic              last;
  } stat_row_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [71:0]  in_tdata = '0;   // category, sample_value, pad
  logic [1:0]   in_tuser = '0;   // mode
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [391:0] out_tdata;       // entry_index, all_count, all_sum, window_count_out,
                                 // window_sum_out, window_max_out, window_min_out, pad
  logic         out_tlast;

  event_item_t send_queue[$];
  stat_row_t   expected_rows[$];

  logic [STAT_W-1:0] total_sum   [NCAT];
  logic [STAT_W-1:0] cum_count   [NCAT];
  logic [STAT_W-1:0] win_sum     [NCAT];
  logic [STAT_W-1:0] win_count   [NCAT];
  logic [STAT_W-1:0] win_max     [NCAT];
  logic [STAT_W-1:0] win_min     [NCAT];

  int unsigned gap_left = 0;
  int unsigned accepted_events = 0;
  int unsigned hold_mark = 32'hffff_ffff;
  int unsigned mismatches = 0;
  int unsigned rx_wait = 0;
  int unsigned hold_left = 0;
  int unsigned idle_cycles = 0;
  bit          hold_done = 1'b0;
  bit          rx_quiet = 1'b0;

  event_statistics_collector dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  task automatic clear_windows();
    for (int k = 0; k < NCAT; k++) begin
      win_sum[k]   = '0;
      win_count[k] = '0;
      win_max[k]   = '0;
      win_min[k]   = '1;
    end
  endtask

  task automatic clear_totals();
    for (int k = 0; k < NCAT; k++) begin
      total_sum[k] = '0;
      cum_count[k] = '0;
    end
  endtask

  task automatic update_statistics(logic [MODE_W-1:0] mode, logic [CAT_W-1:0] cat,
                                   logic [STAT_W-1:0] val);
    stat_row_t row;
    if (mode == MODE_RECORD) begin
      if (cat < NCAT) begin
        total_sum[cat]   = total_sum[cat] + val;
        cum_count[cat]   = cum_count[cat] + 1;
        win_sum[cat]     = win_sum[cat] + val;
        win_count[cat]   = win_count[cat] + 1;
        if (val > win_max[cat]) win_max[cat] = val;
        if (val < win_min[cat]) win_min[cat] = val;
      end
    end else if (mode == MODE_DUMP) begin
      for (int k = 0; k < NCAT; k++) begin
        row.index     = CAT_W'(k);
        row.all_count = cum_count[k];
        row.all_sum   = total_sum[k];
        row.win_count = win_count[k];
        row.win_sum   = win_sum[k];
        row.win_max   = win_max[k];
        // an empty window reports a minimum of zero
        row.win_min   = (win_count[k] != 0) ? win_min[k] : '0;
        row.last      = (k == NCAT - 1);
        expected_rows.push_back(row);
      end
      clear_windows();
    end else if (mode == MODE_CLEAR_TOTALS) begin
      clear_totals();
    end
  endtask

  function automatic void check_field(string name, logic [STAT_W-1:0] want,
                                      logic [STAT_W-1:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("mismatch %s: expected %h, got %h", name, want, got);
    end
  endfunction

  function automatic logic [STAT_W-1:0] draw_sample();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return STAT_W'($urandom_range(0, 15));
      3:       return {1'b1, 31'($urandom), 32'($urandom)};
      default: return {32'($urandom), 32'($urandom)};
    endcase
  endfunction

  task automatic queue_event(logic [MODE_W-1:0] mode, logic [CAT_W-1:0] cat,
                             logic [STAT_W-1:0] val, int unsigned gap, bit drain);
    event_item_t it;
    it.mode     = mode;
    it.category = cat;
    it.sample   = val;
    it.gap      = gap;
    it.drain    = drain;
    send_queue.push_back(it);
  endtask

  // driver: offers the queue head once its gap has passed and, for a drain item, once no results are pending
  always @(posedge clk) begin : driver
    event_item_t it;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (gap_left > 0) begin
        in_tvalid <= 1'b0;
        gap_left  <= gap_left - 1;
      end else if (send_queue.size() > 0 &&
                   (!send_queue[0].drain || (!in_tvalid && expected_rows.size() == 0))) begin
        it = send_queue.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= {4'b0, it.sample, it.category};
        in_tuser  <= it.mode;
        gap_left  <= (send_queue.size() > 0) ? send_queue[0].gap : 0;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver: random stalls, quiet stretches and one long hold-off
  always @(posedge clk) begin : receiver
    int unsigned w;
    int unsigned h;
    if (rst_n) begin
      w = rx_wait;
      h = hold_left;
      if (out_tvalid && out_tready) begin
        if ($urandom_range(0, 39) == 0) rx_quiet = !rx_quiet;
        w = rx_quiet ? 0 : $urandom_range(0, MAX_GAP);
      end else if (w > 0) begin
        w = w - 1;
      end
      if (!hold_done && accepted_events >= hold_mark) begin
        h = HOLD_CYCLES;
        hold_done = 1'b1;
      end else if (h > 0) begin
        h = h - 1;
      end
      rx_wait    <= w;
      hold_left  <= h;
      out_tready <= (w == 0) && (h == 0);
    end
  end

  // monitor: predicts on input transfers, checks output transfers
  always @(posedge clk) begin : monitor
    stat_row_t got;
    stat_row_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        update_statistics(in_tuser, in_tdata[3:0], in_tdata[67:4]);
        accepted_events <= accepted_events + 1;
      end
      if (out_tvalid && out_tready) begin
        got.index     = out_tdata[3:0];
        got.all_count = out_tdata[67:4];
        got.all_sum   = out_tdata[131:68];
        got.win_count = out_tdata[195:132];
        got.win_sum   = out_tdata[259:196];
        got.win_max   = out_tdata[323:260];
        got.win_min   = out_tdata[387:324];
        got.last      = out_tlast;
        if (expected_rows.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("unexpected result transfer for category %0d", got.index);
        end else begin
          want = expected_rows.pop_front();
          check_field("entry_index", want.index, got.index);
          check_field("all_count", want.all_count, got.all_count);
          check_field("all_sum", want.all_sum, got.all_sum);
          check_field("window_count_out", want.win_count, got.win_count);
          check_field("window_sum_out", want.win_sum, got.win_sum);
          check_field("window_max_out", want.win_max, got.win_max);
          check_field("window_min_out", want.win_min, got.win_min);
          check_field("last_entry", want.last, got.last);
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL event_statistics_collector");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    int unsigned pick;
    int unsigned quiet_left;
    int unsigned gap;
    bit          quiet;
    logic [CAT_W-1:0] cat;
    clear_totals();
    clear_windows();

    // directed: empty dump, extremes, wrap, ignored fields and modes
    queue_event(MODE_DUMP, 0, '0, 0, 0);
    queue_event(MODE_RECORD, 0, '0, 0, 0);
    queue_event(MODE_RECORD, 15, '1, 0, 0);
    queue_event(MODE_RECORD, 15, '1, 1, 0);
    queue_event(MODE_RECORD, 3, 64'd1, 0, 0);
    queue_event(MODE_RECORD, 3, '1, 2, 0);
    queue_event(MODE_RECORD, 7, 64'h8000_0000_0000_0000, 0, 0);
    queue_event(MODE_RECORD, 7, 64'h7fff_ffff_ffff_ffff, 0, 0);
    queue_event(MODE_UNUSED, 9, 64'h5555_aaaa_5555_aaaa, 0, 0);
    queue_event(MODE_DUMP, 15, '1, 0, 0);
    queue_event(MODE_DUMP, 6, 64'h1234, 0, 1);
    queue_event(MODE_RECORD, 5, 64'd5, 0, 0);
    queue_event(MODE_RECORD, 12, 64'hdead_beef_0000_0001, 0, 0);
    queue_event(MODE_CLEAR_TOTALS, 5, '1, 0, 0);
    queue_event(MODE_DUMP, 0, '0, 3, 0);
    queue_event(MODE_RECORD, 10, '1, 0, 1);
    queue_event(MODE_UNUSED, 10, '0, 0, 0);
    queue_event(MODE_DUMP, 0, '0, 0, 0);
    queue_event(MODE_CLEAR_TOTALS, 0, '0, 0, 0);
    queue_event(MODE_DUMP, 0, '0, 0, 0);

    // back-to-back burst while the receiver holds off
    hold_mark = send_queue.size() + 4;
    for (int i = 0; i < BURST_ITEMS; i++)
      queue_event((i % 8 == 7) ? MODE_DUMP : MODE_RECORD,
                  CAT_W'($urandom_range(0, NCAT - 1)), draw_sample(), 0, 0);

    quiet = 1'b0;
    quiet_left = 0;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (quiet_left == 0) begin
        quiet = ($urandom_range(0, 2) == 0);
        quiet_left = $urandom_range(10, 40);
      end
      quiet_left--;
      gap = quiet ? 0 : $urandom_range(0, MAX_GAP);
      pick = $urandom_range(0, 99);
      cat = CAT_W'($urandom_range(0, NCAT - 1));
      if (pick < 80)
        queue_event(MODE_RECORD, cat, draw_sample(), gap, 0);
      else if (pick < 91)
        queue_event(MODE_DUMP, cat, draw_sample(), gap, $urandom_range(0, 4) == 0);
      else if (pick < 96)
        queue_event(MODE_CLEAR_TOTALS, cat, draw_sample(), gap, 0);
      else
        queue_event(MODE_UNUSED, cat, draw_sample(), gap, 0);
    end
    queue_event(MODE_DUMP, 0, '0, 0, 0);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (send_queue.size() > 0 || in_tvalid || expected_rows.size() > 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0 && expected_rows.size() == 0)
      $display("PASS event_statistics_collector");
    else
      $display("FAIL event_statistics_collector");
    $finish;
  end

endmodule
